### src/kcd_pkg.sv
// ---------------------------------------------------------------------------
// kcd_pkg
// Shared types and constants for the k-th nearest neighbour core distance block.
// ---------------------------------------------------------------------------
package kcd_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned DistW    = 36;
  localparam int unsigned CoreW    = 18;
  localparam int unsigned CoreSat  = 185363;
  localparam int unsigned StoreAw  = 9;
  localparam int unsigned LoadW    = 10;

  localparam logic [1:0] RegPoints = 2'd0;
  localparam logic [1:0] RegDims   = 2'd1;
  localparam logic [1:0] RegRank   = 2'd2;

  typedef enum logic [3:0] {
    StLoad,
    StPrepI,
    StRdA,
    StRdB,
    StAcc,
    StIns,
    StInsRd,
    StInsWr,
    StSqRd,
    StSqrt,
    StEmit
  } state_e;

  // sqrt unit handshake
  typedef struct packed {
    logic             start;
    logic [DistW-1:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [CoreW-1:0] root;
  } sqrt_rsp_t;

endpackage

### src/knn_core_distance_top.sv
// ---------------------------------------------------------------------------
// knn_core_distance_top
// Loads points into a coordinate RAM, then per point keeps the k smallest squared
// distances in a sorted list RAM and emits the floor root of the k-th (or CoreSat).
// ---------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i         | in
//  coord    | start_i, busy_o, coord_i                | in
//  result   | result_valid_o, point_index_o, core_dist_o, no_neighbor_o, last_o | out
//
// Loading accepts one coordinate per cycle while start_i is high and no register
// write is made. Then each point has a set-up state, per other point reads both
// coordinates per dimension, accumulates and may insert into the list RAM, then
// runs the serial square root and emits; a saturated point skips to the emit.
// Reset clears control only; the RAMs need no clearing. Results cannot be
// stalled; busy_o is high from the final coordinate until the last result.
module knn_core_distance_top #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned MAX_DIMS   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic signed [15:0] coord_i,
  output logic        result_valid_o,
  output logic [5:0]  point_index_o,
  output logic [17:0] core_dist_o,
  output logic        no_neighbor_o,
  output logic        last_o
);

  localparam int unsigned PtW  = $clog2(MAX_POINTS);
  localparam int unsigned DmW  = $clog2(MAX_DIMS + 1);
  localparam int unsigned LstD = MAX_POINTS - 1;
  localparam int unsigned LstW = (LstD > 1) ? $clog2(LstD) : 1;
  localparam int unsigned DistW = kcd_pkg::DistW;

  kcd_pkg::state_e state_q, state_d;

  logic [6:0] npts_q;
  logic [3:0] ndim_q;
  logic [5:0] rank_q;
  logic [kcd_pkg::LoadW-1:0] load_q, load_d;

  // effective configuration
  logic [6:0] n_eff;
  logic [3:0] d_eff;
  logic [5:0] k_eff;
  logic       sat;
  logic [kcd_pkg::LoadW-1:0] total;

  always_comb begin
    n_eff = npts_q;
    if (npts_q < 7'd2) n_eff = 7'd2;
    if (npts_q > 7'(MAX_POINTS)) n_eff = 7'(MAX_POINTS);
    d_eff = ndim_q;
    if (ndim_q == 4'd0) d_eff = 4'd1;
    if (ndim_q > 4'(MAX_DIMS)) d_eff = 4'(MAX_DIMS);
    k_eff = (rank_q == 6'd0) ? 6'd1 : rank_q;
    sat   = ({1'b0, k_eff} >= n_eff);
    total = kcd_pkg::LoadW'(n_eff * d_eff);
  end

  // coordinate RAM
  logic [kcd_pkg::CoordW-1:0] pt_mem [2**kcd_pkg::StoreAw];
  logic [kcd_pkg::StoreAw-1:0] pt_raddr;
  logic [kcd_pkg::CoordW-1:0] pt_rdata_q;
  logic pt_we;

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[load_q[kcd_pkg::StoreAw-1:0]] <= coord_i;
    pt_rdata_q <= pt_mem[pt_raddr];
  end

  // sorted list RAM
  logic [DistW-1:0] ls_mem [LstD];
  logic [LstW-1:0]  ls_waddr, ls_raddr;
  logic [DistW-1:0] ls_wdata, ls_rdata_q;
  logic             ls_we;

  always_ff @(posedge clk_i) begin
    if (ls_we) ls_mem[ls_waddr] <= ls_wdata;
    ls_rdata_q <= ls_mem[ls_raddr];
  end

  // working registers
  logic [PtW-1:0] pi_q, pi_d, pj_q, pj_d;
  logic [DmW-1:0] dim_q, dim_d;
  logic [kcd_pkg::CoordW-1:0] ca_q, ca_d;
  logic [DistW-1:0] acc_q, acc_d;
  logic [5:0] cnt_q, cnt_d, pos_q, pos_d;
  logic [kcd_pkg::CoreW-1:0] core_q, core_d;
  logic       flag_q, flag_d;

  logic signed [16:0] diff;
  logic [16:0] mag;
  logic [33:0] sq;
  logic [kcd_pkg::StoreAw+1:0] ia, ib;

  kcd_pkg::sqrt_req_t sq_req;
  kcd_pkg::sqrt_rsp_t sq_rsp;

  kcd_sqrt u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (sq_req),
    .rsp_o (sq_rsp)
  );

  logic accept, cfg_hit;
  assign accept  = start_i && !busy_o;
  assign cfg_hit = cfg_we_i && (cfg_idx_i == kcd_pkg::RegPoints ||
                   cfg_idx_i == kcd_pkg::RegDims || cfg_idx_i == kcd_pkg::RegRank);
  assign busy_o  = (state_q != kcd_pkg::StLoad);

  assign diff = $signed({ca_q[15], ca_q}) - $signed({pt_rdata_q[15], pt_rdata_q});
  assign mag  = diff[16] ? 17'(-diff) : 17'(diff);
  assign sq   = mag * mag;
  assign ia   = (kcd_pkg::StoreAw+2)'(pi_q * d_eff + dim_q);
  assign ib   = (kcd_pkg::StoreAw+2)'(pj_q * d_eff + dim_q);

  always_comb begin
    state_d = state_q;
    load_d  = load_q;
    pi_d = pi_q; pj_d = pj_q; dim_d = dim_q; ca_d = ca_q; acc_d = acc_q;
    cnt_d = cnt_q; pos_d = pos_q; core_d = core_q; flag_d = flag_q;
    pt_we = 1'b0;
    pt_raddr = ia[kcd_pkg::StoreAw-1:0];
    ls_we = 1'b0;
    ls_waddr = LstW'(pos_q);
    ls_wdata = acc_q;
    ls_raddr = LstW'(k_eff - 6'd1);
    sq_req.start = 1'b0;
    sq_req.value = ls_rdata_q;
    result_valid_o = 1'b0;
    unique case (state_q)
      kcd_pkg::StLoad: begin
        if (cfg_hit) begin
          load_d = '0;
        end else if (accept) begin
          pt_we = 1'b1;
          load_d = load_q + 1'b1;
          if (load_d >= total) begin
            load_d = '0;
            pi_d = '0;
            state_d = kcd_pkg::StPrepI;
          end
        end
      end
      kcd_pkg::StPrepI: begin
        pj_d = '0; cnt_d = '0;
        if (sat) begin
          core_d = kcd_pkg::CoreW'(kcd_pkg::CoreSat); flag_d = 1'b1;
          state_d = kcd_pkg::StEmit;
        end else begin
          flag_d = 1'b0;
          pj_d = (pi_q == '0) ? PtW'(1) : '0;
          dim_d = '0; acc_d = '0;
          state_d = kcd_pkg::StRdA;
        end
      end
      kcd_pkg::StRdA: begin
        pt_raddr = ia[kcd_pkg::StoreAw-1:0];
        state_d = kcd_pkg::StRdB;
      end
      kcd_pkg::StRdB: begin
        ca_d = pt_rdata_q;
        pt_raddr = ib[kcd_pkg::StoreAw-1:0];
        state_d = kcd_pkg::StAcc;
      end
      kcd_pkg::StAcc: begin
        acc_d = acc_q + DistW'(sq);
        if (dim_q == DmW'(d_eff - 4'd1)) begin
          // compare against current k-th when list full
          ls_raddr = LstW'(k_eff - 6'd1);
          state_d = kcd_pkg::StIns;
        end else begin
          dim_d = dim_q + 1'b1;
          state_d = kcd_pkg::StRdA;
        end
      end
      kcd_pkg::StIns: begin
        if (cnt_q == k_eff && acc_q >= ls_rdata_q) begin
          state_d = kcd_pkg::StSqRd; // skip, reuse next-pair logic
        end else begin
          pos_d = (cnt_q < k_eff) ? cnt_q : k_eff - 6'd1;
          if (cnt_q < k_eff) cnt_d = cnt_q + 6'd1;
          ls_raddr = LstW'(pos_d - 6'd1);
          state_d = (pos_d == 6'd0) ? kcd_pkg::StInsWr : kcd_pkg::StInsRd;
        end
      end
      kcd_pkg::StInsRd: begin
        // ls_rdata_q holds list[pos-1]
        if (ls_rdata_q > acc_q) begin
          ls_we = 1'b1; ls_waddr = LstW'(pos_q); ls_wdata = ls_rdata_q;
          pos_d = pos_q - 6'd1;
          ls_raddr = LstW'(pos_d - 6'd1);
          if (pos_d == 6'd0) state_d = kcd_pkg::StInsWr;
        end else begin
          state_d = kcd_pkg::StInsWr;
        end
      end
      kcd_pkg::StInsWr: begin
        ls_we = 1'b1; ls_waddr = LstW'(pos_q); ls_wdata = acc_q;
        state_d = kcd_pkg::StSqRd;
      end
      kcd_pkg::StSqRd: begin
        // advance to next pair or finish the point
        dim_d = '0; acc_d = '0;
        if ({1'b0, pj_q} >= 7'(n_eff - 7'd1) ||
            (pj_q + 1'b1 == pi_q && {1'b0, pi_q} == 7'(n_eff - 7'd1))) begin
          ls_raddr = LstW'(k_eff - 6'd1);
          state_d = kcd_pkg::StSqrt;
          pos_d = '0;
        end else begin
          pj_d = (pj_q + 1'b1 == pi_q) ? pj_q + PtW'(2) : pj_q + 1'b1;
          state_d = kcd_pkg::StRdA;
        end
      end
      kcd_pkg::StSqrt: begin
        if (pos_q == '0) begin
          sq_req.start = 1'b1; sq_req.value = ls_rdata_q;
          pos_d = 6'd1;
        end else if (sq_rsp.done) begin
          core_d = sq_rsp.root;
          state_d = kcd_pkg::StEmit;
        end
      end
      kcd_pkg::StEmit: begin
        result_valid_o = 1'b1;
        if ({1'b0, pi_q} == 7'(n_eff - 7'd1)) begin
          state_d = kcd_pkg::StLoad;
        end else begin
          pi_d = pi_q + 1'b1;
          state_d = kcd_pkg::StPrepI;
        end
      end
      default: state_d = kcd_pkg::StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kcd_pkg::StLoad;
      load_q  <= '0;
      npts_q  <= 7'd16;
      ndim_q  <= 4'd2;
      rank_q  <= 6'd5;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          kcd_pkg::RegPoints: npts_q <= cfg_data_i;
          kcd_pkg::RegDims:   ndim_q <= cfg_data_i[3:0];
          kcd_pkg::RegRank:   rank_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pi_q <= pi_d; pj_q <= pj_d; dim_q <= dim_d; ca_q <= ca_d; acc_q <= acc_d;
    cnt_q <= cnt_d; pos_q <= pos_d; core_q <= core_d; flag_q <= flag_d;
  end

  assign point_index_o = 6'(pi_q);
  assign core_dist_o   = core_q;
  assign no_neighbor_o = flag_q;
  assign last_o        = ({1'b0, pi_q} == 7'(n_eff - 7'd1));

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result outside compute");
  // count is cleared in the per-point set-up state
  a_list_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && state_q != kcd_pkg::StPrepI) |-> cnt_q <= k_eff)
    else $error("list count overrun");
  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && no_neighbor_o) |-> core_dist_o == 18'(kcd_pkg::CoreSat))
    else $error("saturated result wrong");

endmodule

### src/kcd_sqrt.sv
// ---------------------------------------------------------------------------
// kcd_sqrt
// Bit-serial floor square root of a 36-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
module kcd_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kcd_pkg::sqrt_req_t req_i,
  output kcd_pkg::sqrt_rsp_t rsp_o
);

  localparam int unsigned Steps = kcd_pkg::CoreW;

  logic [kcd_pkg::DistW-1:0] rem_q, rem_d;
  logic [kcd_pkg::DistW-1:0] val_q, val_d;
  logic [kcd_pkg::CoreW-1:0] root_q, root_d;
  logic [4:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [kcd_pkg::DistW+1:0] trial;
  logic [kcd_pkg::DistW+1:0] rem_sh;

  always_comb begin
    rem_d  = rem_q;
    val_d  = val_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q, val_q[kcd_pkg::DistW-1 -: 2]};
    trial  = {{(kcd_pkg::DistW-kcd_pkg::CoreW){1'b0}}, root_q, 2'b01};
    if (req_i.start) begin
      rem_d  = '0;
      val_d  = req_i.value;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[kcd_pkg::DistW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = kcd_pkg::DistW'(rem_sh - trial);
        root_d = {root_q[kcd_pkg::CoreW-2:0], 1'b1};
      end else begin
        rem_d  = kcd_pkg::DistW'(rem_sh);
        root_d = {root_q[kcd_pkg::CoreW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    val_q  <= val_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

### sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for knn_core_distance_top: loads point sets, predicts
// the k-th nearest neighbour core distance per point and checks every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [5:0]  idx;
    logic [17:0] cdist;
    logic        nonb;
    logic        last;
  } core_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = kcd_pkg::RegPoints;
  logic [6:0]  cfg_data_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic signed [15:0] coord_i = '0;
  logic        result_valid_o;
  logic [5:0]  point_index_o;
  logic [17:0] core_dist_o;
  logic        no_neighbor_o;
  logic        last_o;

  knn_core_distance_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] pt_mem [512];
  int unsigned ld_cnt;
  int unsigned cf_points = 16, cf_dims = 2, cf_rank = 5;

  logic [15:0] coord_q [$];
  core_res_t   core_q [$];
  int unsigned n_err, n_res, n_sets, cyc;
  bit          quiet_drv;
  bit          gen_done;

  task automatic report(input string what);
    n_err++;
    $display("MISMATCH @%0d: %s", cyc, what);
  endtask

  function automatic longint unsigned pair_dist(int unsigned a, int unsigned b,
                                                int unsigned d);
    longint unsigned s;
    longint df;
    s = 0;
    for (int t = 0; t < d; t++) begin
      df = longint'($signed(pt_mem[(a*d+t) & 511])) - longint'($signed(pt_mem[(b*d+t) & 511]));
      if (df < 0) df = -df;
      s += df * df;
    end
    return s;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_coord(input logic [15:0] c);
    int unsigned n, d, k;
    longint unsigned dl [$];
    longint unsigned cd;
    core_res_t r;
    n = cf_points < 2 ? 2 : (cf_points > 64 ? 64 : cf_points);
    d = cf_dims < 1 ? 1 : (cf_dims > 8 ? 8 : cf_dims);
    k = cf_rank == 0 ? 1 : cf_rank;
    pt_mem[ld_cnt & 511] = c;
    ld_cnt = (ld_cnt + 1) & 1023;
    if (ld_cnt < n * d) return;
    ld_cnt = 0;
    n_sets++;
    for (int i = 0; i < n; i++) begin
      r.idx = i[5:0];
      r.last = (i == n - 1);
      if (k >= n) begin
        r.cdist = 18'(kcd_pkg::CoreSat);
        r.nonb = 1'b1;
      end else begin
        dl.delete();
        for (int j = 0; j < n; j++)
          if (j != i) dl.push_back(pair_dist(i, j, d) & 36'hF_FFFF_FFFF);
        dl.sort();
        cd = floor_root(dl[k-1]);
        if (cd > kcd_pkg::CoreSat) cd = kcd_pkg::CoreSat;
        r.cdist = cd[17:0];
        r.nonb = 1'b0;
      end
      core_q.push_back(r);
    end
  endtask

  // driver
  int unsigned gap;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) predict_coord(coord_i);
      if (gap != 0) begin
        gap <= gap - 1;
        start_i <= 1'b0;
      end else if (coord_q.size() != 0 && !(start_i && !busy_o && coord_q.size() == 0)) begin
        if (start_i && busy_o) begin
          // hold the pending transfer
        end else if (!quiet_drv && $urandom_range(0, 9) == 0) begin
          gap <= $urandom_range(1, 7) - 1;
          start_i <= 1'b0;
        end else begin
          start_i <= 1'b1;
          coord_i <= coord_q.pop_front();
        end
      end else if (!(start_i && busy_o)) begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cyc++;
    if (result_valid_o) begin
      core_res_t e;
      n_res++;
      if (core_q.size() == 0) begin
        report($sformatf("unexpected result point %0d", point_index_o));
      end else begin
        e = core_q.pop_front();
        if (point_index_o !== e.idx)
          report($sformatf("point_index %0d exp %0d", point_index_o, e.idx));
        if (core_dist_o !== e.cdist)
          report($sformatf("pt %0d core_dist %0d exp %0d", e.idx, core_dist_o, e.cdist));
        if (no_neighbor_o !== e.nonb)
          report($sformatf("pt %0d no_neighbor %b exp %b", e.idx, no_neighbor_o, e.nonb));
        if (last_o !== e.last)
          report($sformatf("pt %0d last %b exp %b", e.idx, last_o, e.last));
      end
    end
    if (cyc > 20000000) begin
      $display("knn_core_distance_top test failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (coord_q.size() != 0 || start_i || core_q.size() != 0 || busy_o)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[6:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    // model update aligned with the write edge
    if (idx == kcd_pkg::RegPoints) cf_points = val & 7'h7f;
    else if (idx == kcd_pkg::RegDims) cf_dims = val & 4'hf;
    else if (idx == kcd_pkg::RegRank) cf_rank = val & 6'h3f;
    if (idx <= kcd_pkg::RegRank) ld_cnt = 0;
  endtask

  task automatic set_cfg(input int unsigned n, d, k);
    wait_idle();
    write_reg(kcd_pkg::RegPoints, n);
    write_reg(kcd_pkg::RegDims, d);
    write_reg(kcd_pkg::RegRank, k);
  endtask

  function automatic logic [15:0] rand_coord(input int unsigned mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
      default: return 16'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  task automatic push_set(input int unsigned n, d, mode);
    for (int i = 0; i < n * d; i++) coord_q.push_back(rand_coord(mode));
  endtask

  int unsigned items;
  initial begin
    int unsigned n, d, k;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, ties, rank not below count, out-of-range registers
    set_cfg(2, 1, 1);
    coord_q.push_back(16'h8000); coord_q.push_back(16'h7fff);
    set_cfg(3, 8, 1);
    push_set(3, 8, 1);
    set_cfg(4, 1, 2);
    coord_q.push_back(16'h0000); coord_q.push_back(16'h0000);
    coord_q.push_back(16'h0000); coord_q.push_back(16'hffff);
    set_cfg(3, 1, 3);
    push_set(3, 1, 0);
    set_cfg(0, 0, 0);
    push_set(2, 1, 0);
    set_cfg(127, 9, 63);
    push_set(2, 8, 1);
    // partial load abandoned by a register write
    set_cfg(3, 2, 1);
    coord_q.push_back(16'h1234); coord_q.push_back(16'h5678);
    wait_idle();
    write_reg(kcd_pkg::RegRank, 2);
    write_reg(2'd3, 5);
    push_set(3, 2, 0);
    items = 0;
    while (items < 220) begin
      n = $urandom_range(0, 7) == 0 ? $urandom_range(2, 64) : $urandom_range(2, 8);
      d = $urandom_range(1, 8);
      if (n > 12 && d > 2) d = 2;
      k = $urandom_range(0, 5) == 0 ? $urandom_range(0, 63) : $urandom_range(1, n);
      if (items > 170) quiet_drv = 1;
      set_cfg(n, d, k);
      push_set(n, d, $urandom_range(0, 2));
      items += n * d;
    end
    wait_idle();
    $display("ran %0d point sets, %0d results checked, %0d mismatches",
             n_sets, n_res, n_err);
    if (n_err == 0) $display("knn_core_distance_top test passed");
    else $display("knn_core_distance_top test failed");
    $finish;
  end

endmodule
